@@ hw/rtl/jnp_pkg.sv @@
// ----------------------------------------------------------------------------
// jnp_pkg: shared types and constants of the json nesting prescan unit
// error codes, character codes, configuration and result records
// ----------------------------------------------------------------------------
package jnp_pkg;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_LONG  = 3'd1,
        ERR_ZERO  = 3'd2,
        ERR_NUL   = 3'd3,
        ERR_DEEP  = 3'd4,
        ERR_STRAY = 3'd5,
        ERR_OPEN  = 3'd6
    } err_code_t;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_FRAME = 1'b0;
    localparam logic REG_MAX_NEST  = 1'b1;

    localparam logic [15:0] MAX_FRAME_RESET = 16'd1024;
    localparam logic [3:0]  MAX_NEST_RESET  = 4'd8;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // length of the escaped nul sequence backslash u 0 0 0 0
    localparam logic [2:0] NUL_SEQ_LEN = 3'd6;

    typedef struct packed {
        logic [15:0] max_frame_bytes;
        logic [3:0]  max_nesting;
    } scan_cfg_t;

    typedef struct packed {
        logic        accepted;
        err_code_t   reason;
        logic [16:0] frame_length;
    } scan_result_t;

    function automatic logic [7:0] nul_seq_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CH_BSLASH;
            3'd1:    ch = CH_LOW_U;
            default: ch = CH_ZERO;
        endcase
        return ch;
    endfunction

    // too long wins over all, zero byte over the later ones, else first kept
    function automatic err_code_t raise_err(input err_code_t cur, input err_code_t e);
        err_code_t res;
        if (cur == ERR_NONE || (e <= ERR_ZERO && e < cur)) begin
            res = e;
        end else begin
            res = cur;
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/jnp_scan_core.sv @@
// ----------------------------------------------------------------------------
// jnp_scan_core: running frame state of the prescan
// updates count, quoting, escape and depth state one byte per step
// ----------------------------------------------------------------------------
module jnp_scan_core
    import jnp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  scan_cfg_t    cfg,
    output scan_result_t result
);

    logic [16:0] byte_count_reg, byte_count_next;
    logic [3:0]  nest_depth_reg, nest_depth_next;
    logic        in_string_reg, in_string_next;
    logic        skip_next_reg, skip_next_next;
    logic [2:0]  nul_match_reg, nul_match_next;
    err_code_t   error_reg, error_next;

    logic [16:0] limit;
    logic [16:0] cnt_w;
    logic [3:0]  depth_w;
    logic        str_w;
    logic        skip_w;
    logic [2:0]  match_w;
    err_code_t   err_w;
    err_code_t   fin_err;

    always_comb begin
        limit   = {1'b0, cfg.max_frame_bytes} + 17'd1;
        cnt_w   = byte_count_reg;
        depth_w = nest_depth_reg;
        str_w   = in_string_reg;
        skip_w  = skip_next_reg;
        match_w = nul_match_reg;
        err_w   = error_reg;

        if (cnt_w < limit) begin
            cnt_w = cnt_w + 17'd1;
        end
        if (cnt_w > {1'b0, cfg.max_frame_bytes}) begin
            err_w = raise_err(err_w, ERR_LONG);
        end
        if (data_byte == 8'd0) begin
            err_w = raise_err(err_w, ERR_ZERO);
        end

        // escaped nul tracking
        if (err_w == ERR_NONE && match_w != 3'd0) begin
            if (match_w < NUL_SEQ_LEN && data_byte == nul_seq_char(match_w)) begin
                match_w = match_w + 3'd1;
                if (match_w >= NUL_SEQ_LEN) begin
                    err_w   = raise_err(err_w, ERR_NUL);
                    match_w = 3'd0;
                end
            end else begin
                match_w = 3'd0;
            end
        end

        // quoting and nesting freeze once an error is seen
        if (err_w == ERR_NONE) begin
            if (skip_w) begin
                skip_w = 1'b0;
            end else if (str_w && data_byte == CH_BSLASH) begin
                skip_w  = 1'b1;
                match_w = 3'd1;
            end else if (data_byte == CH_QUOTE) begin
                str_w = ~str_w;
            end else if (!str_w && (data_byte == CH_LBRACE || data_byte == CH_LBRACK)) begin
                if (({1'b0, depth_w} + 5'd1) > {1'b0, cfg.max_nesting}) begin
                    err_w = raise_err(err_w, ERR_DEEP);
                end else begin
                    depth_w = depth_w + 4'd1;
                end
            end else if (!str_w && (data_byte == CH_RBRACE || data_byte == CH_RBRACK)) begin
                if (depth_w == 4'd0) begin
                    err_w = raise_err(err_w, ERR_STRAY);
                end else begin
                    depth_w = depth_w - 4'd1;
                end
            end
        end

        fin_err = err_w;
        if (err_w == ERR_NONE && (str_w || depth_w != 4'd0)) begin
            fin_err = ERR_OPEN;
        end

        result.accepted     = (fin_err == ERR_NONE);
        result.reason       = fin_err;
        result.frame_length = cnt_w;

        byte_count_next = byte_count_reg;
        nest_depth_next = nest_depth_reg;
        in_string_next  = in_string_reg;
        skip_next_next  = skip_next_reg;
        nul_match_next  = nul_match_reg;
        error_next      = error_reg;
        if (step) begin
            if (last_byte) begin
                byte_count_next = 17'd0;
                nest_depth_next = 4'd0;
                in_string_next  = 1'b0;
                skip_next_next  = 1'b0;
                nul_match_next  = 3'd0;
                error_next      = ERR_NONE;
            end else begin
                byte_count_next = cnt_w;
                nest_depth_next = depth_w;
                in_string_next  = str_w;
                skip_next_next  = skip_w;
                nul_match_next  = match_w;
                error_next      = err_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 17'd0;
            nest_depth_reg <= 4'd0;
            in_string_reg  <= 1'b0;
            skip_next_reg  <= 1'b0;
            nul_match_reg  <= 3'd0;
            error_reg      <= ERR_NONE;
        end else begin
            byte_count_reg <= byte_count_next;
            nest_depth_reg <= nest_depth_next;
            in_string_reg  <= in_string_next;
            skip_next_reg  <= skip_next_next;
            nul_match_reg  <= nul_match_next;
            error_reg      <= error_next;
        end
    end

    a_skip_in_string: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_next_reg |-> in_string_reg)
        else $error("escape skip pending outside a string");

    a_match_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nul_match_reg < NUL_SEQ_LEN)
        else $error("nul match counter out of range");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && last_byte) |=> (byte_count_reg == 17'd0 && error_reg == ERR_NONE))
        else $error("frame state not cleared after last byte");

endmodule

@@ hw/rtl/json_nesting_prescan_unit.sv @@
// ----------------------------------------------------------------------------
// json_nesting_prescan_unit: streaming structural check of json messages
// one byte per clock unless stalled; verdict, reason, length on final byte
// ----------------------------------------------------------------------------
// each byte sits in the input register; a final byte's verdict then
// loads the result register and raises m_valid
// throughput: one byte per cycle; a final byte waits only while an untaken
// verdict holds the result register
// reset: synchronous active-low aresetn clears frame state and both valid
// flags; max_frame_bytes resets to 1024 and max_nesting to 8
module json_nesting_prescan_unit
    import jnp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // byte stream in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,

    // verdict out
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [2:0]  m_reason,
    output logic [16:0] m_frame_length
);

    // configuration registers
    scan_cfg_t cfg_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result stage
    logic         m_valid_reg;
    scan_result_t res_reg;

    scan_result_t core_result;
    logic         advance;
    logic         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_frame_bytes <= MAX_FRAME_RESET;
            cfg_reg.max_nesting     <= MAX_NEST_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_MAX_FRAME: cfg_reg.max_frame_bytes <= pwdata[15:0];
                REG_MAX_NEST:  cfg_reg.max_nesting     <= pwdata[3:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MAX_FRAME: prdata = {16'd0, cfg_reg.max_frame_bytes};
            REG_MAX_NEST:  prdata = {28'd0, cfg_reg.max_nesting};
            default:       prdata = 32'd0;
        endcase
    end

    // the held byte moves on unless it is a final byte and the verdict
    // register is still full and not being taken
    assign advance = in_valid_reg && !(in_last_reg && m_valid_reg && !m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    jnp_scan_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg_reg),
        .result    (core_result)
    );

    // verdict register, loaded only by a final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            res_reg <= core_result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_accepted     = res_reg.accepted;
    assign m_reason       = res_reg.reason;
    assign m_frame_length = res_reg.frame_length;

    a_accept_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (res_reg.accepted == (res_reg.reason == ERR_NONE)))
        else $error("accepted flag disagrees with reason");

    a_length_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (res_reg.frame_length != 17'd0))
        else $error("verdict with zero frame length");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(advance && in_last_reg))
        else $error("verdict overwritten before it was taken");

endmodule

@@ dv/json_nesting_prescan_unit_tb.sv @@
// ----------------------------------------------------------------------------
// json_nesting_prescan_unit_tb: self-checking bench of the json prescan unit
// streams messages through the byte port under random bursts and output
// stalls, predicts each verdict from its own copy of the frame state, and
// compares verdicts in order; limits are changed over apb between phases
// ----------------------------------------------------------------------------
module json_nesting_prescan_unit_tb;
    import jnp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 4;
    // the verdict passes the input and result registers, keep some margin
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    // no transfer of any kind for this long means the block is stuck
    localparam int STALL_LIMIT  = 4000;

    // receiver behaviors between long hold-offs
    localparam int SINK_OPEN   = 0;
    localparam int SINK_COIN   = 1;
    localparam int SINK_SPARSE = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte   = '0;
    logic        s_last_byte   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_accepted;
    logic [2:0]  m_reason;
    logic [16:0] m_frame_length;

    json_nesting_prescan_unit u_top (.*);

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // verdict predictor: limits and running frame state
    // ------------------------------------------------------------------------
    logic [15:0]  cfg_max_frame = MAX_FRAME_RESET;
    logic [3:0]   cfg_max_nest  = MAX_NEST_RESET;
    logic [16:0]  run_count     = '0;
    logic [3:0]   run_depth     = '0;
    logic         in_str        = 1'b0;
    logic         skip_one      = 1'b0;
    logic [2:0]   nul_hits      = '0;
    err_code_t    run_err       = ERR_NONE;

    scan_result_t verdicts_due[$];

    // first error sticks, except that too long and zero byte take over
    function automatic void note_error(input err_code_t e);
        if (run_err == ERR_NONE || (e <= ERR_ZERO && e < run_err)) begin
            run_err = e;
        end
    endfunction

    function automatic void track_byte(input logic [7:0] ch, input logic last);
        logic [16:0]  cap;
        scan_result_t v;
        cap = {1'b0, cfg_max_frame} + 17'd1;
        if (run_count < cap) begin
            run_count = run_count + 17'd1;
        end
        if (run_count > {1'b0, cfg_max_frame}) begin
            note_error(ERR_LONG);
        end
        if (ch == 8'h00) begin
            note_error(ERR_ZERO);
        end

        // partial match of backslash u 0 0 0 0, started by the escape below
        if (run_err == ERR_NONE && nul_hits != 3'd0) begin
            if (nul_hits < NUL_SEQ_LEN
                && ch == ((nul_hits == 3'd1) ? CH_LOW_U : CH_ZERO)) begin
                nul_hits = nul_hits + 3'd1;
                if (nul_hits >= NUL_SEQ_LEN) begin
                    note_error(ERR_NUL);
                    nul_hits = 3'd0;
                end
            end else begin
                nul_hits = 3'd0;
            end
        end

        // structure tracking freezes once any error is seen
        if (run_err == ERR_NONE) begin
            if (skip_one) begin
                skip_one = 1'b0;
            end else if (in_str && ch == CH_BSLASH) begin
                skip_one = 1'b1;
                nul_hits = 3'd1;
            end else if (ch == CH_QUOTE) begin
                in_str = !in_str;
            end else if (!in_str && (ch == CH_LBRACE || ch == CH_LBRACK)) begin
                if ({1'b0, run_depth} + 5'd1 > {1'b0, cfg_max_nest}) begin
                    note_error(ERR_DEEP);
                end else begin
                    run_depth = run_depth + 4'd1;
                end
            end else if (!in_str && (ch == CH_RBRACE || ch == CH_RBRACK)) begin
                if (run_depth == 4'd0) begin
                    note_error(ERR_STRAY);
                end else begin
                    run_depth = run_depth - 4'd1;
                end
            end
        end

        if (last) begin
            if (run_err == ERR_NONE && (in_str || run_depth != 4'd0)) begin
                run_err = ERR_OPEN;
            end
            v.accepted     = (run_err == ERR_NONE);
            v.reason       = run_err;
            v.frame_length = run_count;
            verdicts_due.push_back(v);
            run_count = '0;
            run_depth = '0;
            in_str    = 1'b0;
            skip_one  = 1'b0;
            nul_hits  = '0;
            run_err   = ERR_NONE;
        end
    endfunction

    // ------------------------------------------------------------------------
    // message builder: bytes collect in msg_buf, then go to the driver queue
    // ------------------------------------------------------------------------
    stream_byte_t bytes_waiting[$];
    logic [7:0]   msg_buf[$];
    int           bytes_queued = 0;
    int           bytes_taken  = 0;

    function automatic void add_byte(input logic [7:0] b);
        msg_buf.push_back(b);
    endfunction

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            add_byte(s[k]);
        end
    endfunction

    // hand the collected message to the driver, last mark on its final byte
    function automatic void post_msg();
        for (int k = 0; k < msg_buf.size(); k++) begin
            bytes_waiting.push_back({msg_buf[k], k == msg_buf.size() - 1});
            bytes_queued++;
        end
        msg_buf.delete();
    endfunction

    function automatic logic [7:0] pick_special();
        logic [7:0] ch;
        case ($urandom_range(0, 7))
            0:       ch = CH_LBRACE;
            1:       ch = CH_LBRACK;
            2:       ch = CH_RBRACE;
            3:       ch = CH_RBRACK;
            4:       ch = CH_QUOTE;
            5:       ch = CH_BSLASH;
            6:       ch = CH_LOW_U;
            default: ch = CH_ZERO;
        endcase
        return ch;
    endfunction

    function automatic void add_escaped_nul();
        add_byte(CH_BSLASH);
        add_byte(CH_LOW_U);
        repeat (4) add_byte(CH_ZERO);
    endfunction

    function automatic void add_string();
        int         n;
        logic [7:0] ch;
        add_byte(CH_QUOTE);
        n = $urandom_range(0, 5);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    // escape of any nonzero byte, quote and backslash included
                    add_byte(CH_BSLASH);
                    add_byte(8'($urandom_range(1, 255)));
                end
                1: begin
                    // near miss or rare hit of the escaped nul
                    add_byte(CH_BSLASH);
                    add_byte(CH_LOW_U);
                    add_byte(CH_ZERO);
                    add_byte(CH_ZERO);
                    add_byte(CH_ZERO);
                    add_byte(($urandom_range(0, 3) == 0) ? CH_ZERO
                                                         : 8'($urandom_range(49, 70)));
                end
                2: add_byte(pick_special() == CH_QUOTE ? CH_LBRACE : CH_RBRACK);
                default: begin
                    ch = 8'($urandom_range(32, 126));
                    add_byte((ch == CH_QUOTE || ch == CH_BSLASH) ? "x" : ch);
                end
            endcase
        end
        add_byte(CH_QUOTE);
    endfunction

    function automatic void add_scalar();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            add_byte($urandom_range(0, 1) ? 8'($urandom_range(48, 57))
                                          : 8'($urandom_range(97, 122)));
        end
    endfunction

    // random tokens with balanced braces and brackets, depth at most cap
    function automatic void add_doc(input int depth_cap);
        logic [7:0] closers[$];
        int         steps;
        int         pick;
        steps = $urandom_range(1, 10);
        for (int k = 0; k < steps; k++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 2 && closers.size() < depth_cap) begin
                if ($urandom_range(0, 1) == 1) begin
                    add_byte(CH_LBRACE);
                    closers.push_back(CH_RBRACE);
                end else begin
                    add_byte(CH_LBRACK);
                    closers.push_back(CH_RBRACK);
                end
            end else if (pick <= 4 && closers.size() > 0) begin
                add_byte(closers.pop_back());
            end else if (pick <= 6) begin
                add_string();
            end else if (pick <= 8) begin
                add_scalar();
            end else begin
                add_byte($urandom_range(0, 1) ? "," : ":");
            end
        end
        while (closers.size() > 0) begin
            add_byte(closers.pop_back());
        end
    endfunction

    function automatic void make_message();
        int         pick;
        int         levels;
        int         idx;
        int         n;
        logic [7:0] closers[$];
        pick = $urandom_range(0, 19);
        if (pick <= 9) begin
            add_doc(int'(cfg_max_nest));
        end else if (pick <= 11) begin
            // nest right up to the limit, sometimes one past it
            levels = int'(cfg_max_nest) + $urandom_range(0, 1);
            for (int k = 0; k < levels; k++) begin
                if ($urandom_range(0, 1) == 1) begin
                    add_byte(CH_LBRACE);
                    closers.push_back(CH_RBRACE);
                end else begin
                    add_byte(CH_LBRACK);
                    closers.push_back(CH_RBRACK);
                end
            end
            add_string();
            while (closers.size() > 0) begin
                add_byte(closers.pop_back());
            end
        end else if (pick <= 14) begin
            // broken document: one byte changed, tail cut, or a zero inserted
            add_doc(int'(cfg_max_nest) + 1);
            idx = $urandom_range(0, msg_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: msg_buf[idx] = 8'($urandom_range(0, 255));
                1: while (msg_buf.size() > idx + 1) void'(msg_buf.pop_back());
                default: msg_buf.insert(idx, 8'h00);
            endcase
        end else if (pick <= 16) begin
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++) begin
                add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                              : pick_special());
            end
        end else if (pick == 17) begin
            add_byte(CH_QUOTE);
            add_escaped_nul();
            if ($urandom_range(0, 1) == 1) add_byte(CH_QUOTE);
        end else begin
            // pad a document around the frame limit while the limit is small
            add_doc(int'(cfg_max_nest));
            if (cfg_max_frame <= 16'd64) begin
                n = int'(cfg_max_frame) + $urandom_range(0, 2);
                while (msg_buf.size() < n) add_byte(" ");
            end
        end
        if (msg_buf.size() == 0) begin
            add_byte(" ");
        end
    endfunction

    function automatic void fill_random(input int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            make_message();
            sent += msg_buf.size();
            post_msg();
        end
    endfunction

    // ------------------------------------------------------------------------
    // byte driver: bursts of random length with random gaps in between
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin : byte_driver
        logic         busy;
        stream_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid && !s_ready;
            // request taken at this edge: predict from the presented byte
            if (s_valid && s_ready) begin
                track_byte(s_data_byte, s_last_byte);
                bytes_taken++;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (bytes_waiting.size() > 0) begin
                    nxt = bytes_waiting.pop_front();
                    s_valid     <= 1'b1;
                    s_data_byte <= nxt.data;
                    s_last_byte <= nxt.last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // long unbroken runs now and then, short choppy ones mostly
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // verdict sink: stall pattern of its own, long hold-off on request
    // ------------------------------------------------------------------------
    int          hold_tokens = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          sink_mode   = SINK_OPEN;
    int          mode_left   = 0;
    int unsigned fail_count  = 0;

    always @(posedge aclk) begin : verdict_sink
        scan_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict with none pending: reason %0d length %0d",
                           m_reason, m_frame_length);
                    fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_accepted !== want.accepted) begin
                        $error("accepted: expected %0b, got %0b", want.accepted, m_accepted);
                        fail_count++;
                    end
                    if (m_reason !== want.reason) begin
                        $error("reason: expected %0d, got %0d", want.reason, m_reason);
                        fail_count++;
                    end
                    if (m_frame_length !== want.frame_length) begin
                        $error("frame_length: expected %0d, got %0d",
                               want.frame_length, m_frame_length);
                        fail_count++;
                    end
                end
            end

            // a new hold token starts a long stretch with ready low
            if (hold_seen != hold_tokens) begin
                hold_seen = hold_tokens;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    sink_mode = $urandom_range(SINK_OPEN, SINK_SPARSE);
                    mode_left = $urandom_range(16, 128);
                end else begin
                    mode_left--;
                end
                case (sink_mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                    default:     m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transfer on any port
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // phases
    // ------------------------------------------------------------------------
    // every byte taken and every verdict seen, then let the pipeline empty
    task automatic settle();
        while (!(bytes_taken == bytes_queued && verdicts_due.size() == 0)) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup cycle, access cycle, register loads at the access edge
    task automatic cfg_write(input logic sel, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_MAX_FRAME) begin
            cfg_max_frame = value[15:0];
        end else begin
            cfg_max_nest = value[3:0];
        end
    endtask

    task automatic set_limits(input int unsigned frame, input int unsigned nest);
        cfg_write(REG_MAX_FRAME, 32'(frame));
        cfg_write(REG_MAX_NEST, 32'(nest));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limits: zero byte, stray closer, escaped nul, open frames and the plain cases
        add_text("{}");
        post_msg();
        add_byte(8'h00);
        post_msg();
        add_text("}");
        post_msg();
        add_text("\"\\u0000");
        post_msg();
        // escape cut by the end of the message leaves the string open
        add_text("\"\\u00");
        post_msg();
        // backslash as the final byte inside a string
        add_text("\"\\");
        post_msg();
        add_text("[");
        post_msg();
        add_byte(8'hFF);
        post_msg();
        fill_random(200);
        settle();

        // zero frame limit: every message is too long
        set_limits(0, 15);
        add_text("x");
        post_msg();
        fill_random(40);
        settle();

        // zero nesting: every opener is too deep; widest frame limit
        set_limits(65535, 0);
        add_text("[");
        post_msg();
        fill_random(150);
        settle();

        // tightest nonzero limits, length saturates at two
        set_limits(1, 1);
        add_text("{}");
        post_msg();
        fill_random(60);
        settle();

        // short frames while the sink holds off so the input backs up
        set_limits(20, 1);
        add_text("[[");
        post_msg();
        hold_tokens++;
        fill_random(300);
        settle();

        set_limits(65535, 15);
        fill_random(250);
        settle();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
